>>> hdl/rmla_pkg.sv
package rmla_pkg;

  // fixed field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MEAN_W   = 32;
  localparam int unsigned COMO_W   = 64;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned AC_W     = 16;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned FRAC_W   = 16;

  // divider geometry
  localparam int unsigned DIV_W  = 64;
  localparam int unsigned STEP_W = 7;

  // division lengths in steps
  localparam logic [STEP_W-1:0] STEPS_TERM  = 7'd48;
  localparam logic [STEP_W-1:0] STEPS_MEAN  = 7'd32;
  localparam logic [STEP_W-1:0] STEPS_VAR   = 7'd64;
  localparam logic [STEP_W-1:0] STEPS_RATIO = 7'd15;

  // autocorrelation saturation codes
  localparam logic [AC_W-1:0] AC_POS_SAT = 16'h7fff;
  localparam logic [AC_W-1:0] AC_NEG_SAT = 16'h8000;

  // one lag record held by a cell
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [MEAN_W-1:0]   mean;
    logic signed [COMO_W-1:0]   como;
  } rec_t;

  // cell control
  typedef struct packed {
    logic shift;
    logic rot;
  } cell_ctl_t;

  // divider request
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  rem0;
    logic [DIV_W-1:0]  den;
  } div_req_t;

  // signed 64-bit add with saturation
  function automatic logic signed [COMO_W-1:0] sat_add64(
    input logic signed [COMO_W-1:0] a,
    input logic signed [COMO_W-1:0] b
  );
    logic [COMO_W:0] s;
    s = {a[COMO_W-1], a} + {b[COMO_W-1], b};
    if (s[COMO_W] != s[COMO_W-1]) begin
      sat_add64 = s[COMO_W] ? {1'b1, {(COMO_W-1){1'b0}}} : {1'b0, {(COMO_W-1){1'b1}}};
    end else begin
      sat_add64 = s[COMO_W-1:0];
    end
  endfunction

endpackage

>>> hdl/rmla_if.sv
interface rmla_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rmla_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        sample_count;
  logic signed [31:0] running_mean;
  logic signed [63:0] sample_variance;
  logic signed [31:0] lag_mean;
  logic signed [63:0] lag_comoment;
  logic signed [15:0] autocorrelation;
  modport source (output valid, output sample_count, output running_mean,
                  output sample_variance, output lag_mean, output lag_comoment,
                  output autocorrelation, input ready);
  modport sink   (input valid, input sample_count, input running_mean,
                  input sample_variance, input lag_mean, input lag_comoment,
                  input autocorrelation, output ready);
endinterface

interface rmla_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] query_lag;
  modport source (output valid, output query_lag, input ready);
  modport sink   (input valid, input query_lag, output ready);
endinterface

>>> hdl/rmla_cell.sv
module rmla_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rmla_pkg::cell_ctl_t        ctl_i,
  input  logic signed [15:0]         shift_sample_i,
  input  rmla_pkg::rec_t             rot_rec_i,
  output rmla_pkg::rec_t             rec_o
);
  import rmla_pkg::*;

  rec_t rec_q;

  // rotate takes the whole record from the next cell, shift moves samples only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else if (ctl_i.rot) begin
      rec_q <= rot_rec_i;
    end else if (ctl_i.shift) begin
      rec_q.sample <= shift_sample_i;
    end
  end

  assign rec_o = rec_q;

endmodule

>>> hdl/rmla_div.sv
module rmla_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmla_pkg::div_req_t  req_i,
  output logic                done_o,
  output logic [63:0]         quo_o
);
  import rmla_pkg::*;

  logic [DIV_W-1:0]  rem_q, num_q, den_q, quo_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [DIV_W:0]    sh;
  logic              fit;

  // one restoring step per cycle
  assign sh  = {rem_q, num_q[DIV_W-1]};
  assign fit = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem0;
      num_q <= req_i.num;
      den_q <= req_i.den;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fit ? DIV_W'(sh - {1'b0, den_q}) : sh[DIV_W-1:0];
      num_q <= {num_q[DIV_W-2:0], 1'b0};
      quo_q <= {quo_q[DIV_W-2:0], fit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> hdl/running_mean_lag_autocovariance.sv
// channel   dir  payload                                    beat when
// in_i      in   sample                                     valid && ready
// cfg_i     in   query_lag                                  valid && ready
// out_o     out  count, mean, variance, lag mean/comoment,  valid && ready
//                autocorrelation
//
// one sample at a time
// each held lag makes two passes of the shared bit-serial divider (48 and
// 32 steps), then the variance takes one pass and the autocorrelation at most
// one; empty lags take only a check and a rotate
// reset clears all lag records, the count and the query lag at once
// a waiting result holds its register; the next sample is still taken
module running_mean_lag_autocovariance #(
  parameter int unsigned MAX_LAG = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  rmla_in_if.sink    in_i,
  rmla_cfg_if.sink   cfg_i,
  rmla_out_if.source out_o
);
  import rmla_pkg::*;

  localparam int unsigned WIN_DEPTH = MAX_LAG + 1;
  localparam int unsigned LAG_W  = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(WIN_DEPTH + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LAG  = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_D1S  = 4'd3;
  localparam logic [3:0] ST_D1W  = 4'd4;
  localparam logic [3:0] ST_D2S  = 4'd5;
  localparam logic [3:0] ST_D2W  = 4'd6;
  localparam logic [3:0] ST_ROT  = 4'd7;
  localparam logic [3:0] ST_VS   = 4'd8;
  localparam logic [3:0] ST_VW   = 4'd9;
  localparam logic [3:0] ST_AS   = 4'd10;
  localparam logic [3:0] ST_AW   = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  logic [3:0]              state_q, state_d;
  logic [CFG_W-1:0]        query_q;
  logic [COUNT_W-1:0]      n_q;
  logic [FILL_W-1:0]       fill_q;
  logic [LAG_W-1:0]        idx_q, lag_q;
  logic signed [15:0]      x_q;
  logic signed [31:0]      m0_q;
  logic                    do_q;
  logic [63:0]             prod_q;
  logic                    pneg_q, msign_q;
  logic signed [63:0]      como_new_q;
  logic signed [31:0]      mean_new_q;
  logic signed [63:0]      c0_q, lagc_q, var_q;
  logic signed [31:0]      mean0_q, lagm_q;
  logic [15:0]             ac_q;

  logic                    out_valid_q;
  logic [31:0]             o_count_q;
  logic signed [31:0]      o_mean_q, o_lagm_q;
  logic signed [63:0]      o_var_q, o_lagc_q;
  logic [15:0]             o_ac_q;

  logic                    in_acc;
  cell_ctl_t               ctl;
  rec_t                    recs [WIN_DEPTH];
  rec_t                    head, upd_rec;
  div_req_t                div_req;
  logic                    div_done;
  logic [63:0]             quo;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // query lag register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q <= '0;
    end else if (cfg_i.valid) begin
      query_q <= cfg_i.query_lag;
    end
  end

  // chain of lag cells, head at index zero
  assign ctl.shift = in_acc;
  assign ctl.rot   = (state_q == ST_ROT);
  assign head      = recs[0];

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    logic signed [15:0] sh_in;
    rec_t               rot_in;
    if (i == 0) begin : g_first
      assign sh_in = in_i.sample;
    end else begin : g_mid
      assign sh_in = recs[i-1].sample;
    end
    if (i == WIN_DEPTH - 1) begin : g_last
      assign rot_in = upd_rec;
    end else begin : g_inner
      assign rot_in = recs[i+1];
    end
    rmla_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctl_i          (ctl),
      .shift_sample_i (sh_in),
      .rot_rec_i      (rot_in),
      .rec_o          (recs[i])
    );
  end

  // deviations from the old lag-zero mean, and of the sample from the current lag's mean
  logic signed [33:0] d1, d2, dm;
  logic [31:0]        mag1, mag2, magm;
  assign d1   = {{2{x_q[15]}}, x_q, 16'b0} - {{2{m0_q[31]}}, m0_q};
  assign d2   = {{2{head.sample[15]}}, head.sample, 16'b0} - {{2{m0_q[31]}}, m0_q};
  assign dm   = {{2{x_q[15]}}, x_q, 16'b0} - {{2{head.mean[31]}}, head.mean};
  assign mag1 = d1[33] ? 32'(-d1) : d1[31:0];
  assign mag2 = d2[33] ? 32'(-d2) : d2[31:0];
  assign magm = dm[33] ? 32'(-dm) : dm[31:0];

  // updated head record handed to the tail
  always_comb begin
    upd_rec        = head;
    upd_rec.mean   = do_q ? mean_new_q : head.mean;
    upd_rec.como   = do_q ? como_new_q : head.como;
  end

  // co-moment term and mean step from the divider quotient
  logic [47:0]        xm, tmag;
  logic signed [63:0] term;
  logic [31:0]        mq;
  assign xm   = prod_q[63:16];
  assign tmag = xm - quo[47:0];
  assign term = pneg_q ? -$signed({16'b0, tmag}) : $signed({16'b0, tmag});
  assign mq   = msign_q ? 32'(-quo[31:0]) : quo[31:0];

  // final ratio operands
  logic [63:0] amag, dmag;
  logic        aneg;
  assign amag = lagc_q[63] ? 64'(-lagc_q) : lagc_q;
  assign dmag = c0_q[63] ? 64'(-c0_q) : c0_q;
  assign aneg = lagc_q[63] ^ c0_q[63];

  // divider requests
  always_comb begin
    div_req = '0;
    case (state_q)
      ST_D1S: begin
        div_req.start = 1'b1;
        div_req.steps = STEPS_TERM;
        div_req.num   = {xm, 16'b0};
        div_req.den   = {32'b0, n_q};
      end
      ST_D2S: begin
        div_req.start = 1'b1;
        div_req.steps = STEPS_MEAN;
        div_req.num   = {magm, 32'b0};
        div_req.den   = {32'b0, n_q - 32'(idx_q)};
      end
      ST_VS: begin
        div_req.start = 1'b1;
        div_req.steps = STEPS_VAR;
        div_req.num   = dmag;
        div_req.den   = {32'b0, n_q};
      end
      ST_AS: begin
        div_req.start = (c0_q != '0) && (amag < dmag);
        div_req.steps = STEPS_RATIO;
        div_req.rem0  = amag;
        div_req.den   = dmag;
      end
      default: div_req = '0;
    endcase
  end

  rmla_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_LAG;
      ST_LAG:  state_d = (FILL_W'(idx_q) < fill_q) ? ST_MUL : ST_ROT;
      ST_MUL:  state_d = ST_D1S;
      ST_D1S:  state_d = ST_D1W;
      ST_D1W:  if (div_done) state_d = ST_D2S;
      ST_D2S:  state_d = ST_D2W;
      ST_D2W:  if (div_done) state_d = ST_ROT;
      ST_ROT:  state_d = (idx_q == LAG_W'(MAX_LAG)) ? ST_VS : ST_LAG;
      ST_VS:   state_d = ST_VW;
      ST_VW:   if (div_done) state_d = ST_AS;
      ST_AS:   state_d = div_req.start ? ST_AW : ST_OUT;
      ST_AW:   if (div_done) state_d = ST_OUT;
      ST_OUT:  if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      fill_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (n_q != '1) n_q <= n_q + 1'b1;
        if (fill_q != FILL_W'(WIN_DEPTH)) fill_q <= fill_q + 1'b1;
        idx_q <= '0;
      end
      if (state_q == ST_ROT) idx_q <= idx_q + 1'b1;
      if (state_q == ST_OUT && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q   <= in_i.sample;
      m0_q  <= head.mean;
      lag_q <= ({3'b0, query_q} > 7'(MAX_LAG)) ? LAG_W'(MAX_LAG) : LAG_W'(query_q);
    end
    if (state_q == ST_LAG) do_q <= FILL_W'(idx_q) < fill_q;
    if (state_q == ST_MUL) begin
      prod_q <= 64'(mag1) * 64'(mag2);
      pneg_q <= d1[33] ^ d2[33];
    end
    if (state_q == ST_D1W && div_done) como_new_q <= sat_add64(head.como, term);
    if (state_q == ST_D2S) msign_q <= dm[33];
    if (state_q == ST_D2W && div_done) mean_new_q <= head.mean + $signed(mq);
    if (state_q == ST_ROT) begin
      if (idx_q == '0) begin
        c0_q    <= upd_rec.como;
        mean0_q <= upd_rec.mean;
      end
      if (idx_q == lag_q) begin
        lagc_q <= upd_rec.como;
        lagm_q <= upd_rec.mean;
      end
    end
    if (state_q == ST_VW && div_done) var_q <= c0_q[63] ? -$signed(quo) : $signed(quo);
    if (state_q == ST_AS && !div_req.start) begin
      if (c0_q == '0) ac_q <= '0;
      else            ac_q <= aneg ? AC_NEG_SAT : AC_POS_SAT;
    end
    if (state_q == ST_AW && div_done) begin
      ac_q <= aneg ? 16'(-{1'b0, quo[14:0]}) : {1'b0, quo[14:0]};
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && (!out_valid_q || out_o.ready)) begin
      o_count_q <= n_q;
      o_mean_q  <= mean0_q;
      o_var_q   <= var_q;
      o_lagm_q  <= lagm_q;
      o_lagc_q  <= lagc_q;
      o_ac_q    <= ac_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.sample_count    = o_count_q;
  assign out_o.running_mean    = o_mean_q;
  assign out_o.sample_variance = o_var_q;
  assign out_o.lag_mean        = o_lagm_q;
  assign out_o.lag_comoment    = o_lagc_q;
  assign out_o.autocorrelation = o_ac_q;

endmodule

>>> hdl/rmla_checker.sv
module rmla_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [31:0]        sample_count_i,
  input logic signed [31:0] running_mean_i,
  input logic signed [63:0] lag_comoment_i,
  input logic signed [15:0] autocorrelation_i
);

  // one sample in flight: no beat right after an input beat
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken twice in a row");

  // every result counts at least its own sample
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> sample_count_i != '0)
    else $error("result with zero count");

  // zero lag co-moment gives zero correlation
  a_ac_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && lag_comoment_i == '0 |-> autocorrelation_i == '0)
    else $error("nonzero autocorrelation with zero co-moment");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(running_mean_i))
    else $error("stalled result changed");

endmodule

bind running_mean_lag_autocovariance rmla_checker u_rmla_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .sample_count_i    (out_o.sample_count),
  .running_mean_i    (out_o.running_mean),
  .lag_comoment_i    (out_o.lag_comoment),
  .autocorrelation_i (out_o.autocorrelation)
);

>>> sim/running_mean_lag_autocovariance_test.sv
module running_mean_lag_autocovariance_test;
  import rmla_pkg::*;

  localparam int unsigned LAGS      = 8;
  localparam int unsigned DEPTH     = LAGS + 1;
  localparam int unsigned RAND_N    = 1000;
  localparam int unsigned QUIET_N   = 100;
  localparam int unsigned SETTLE    = 900;
  localparam int unsigned REPORT_N  = 10;
  localparam int unsigned NO_CFG    = 255;
  localparam longint      SAT_MAX   = 64'sh7fffffffffffffff;
  localparam longint      SAT_MIN   = 64'sh8000000000000000;

  typedef struct packed {
    logic [COUNT_W-1:0]        count;
    logic signed [MEAN_W-1:0]  mean;
    logic signed [COMO_W-1:0]  variance;
    logic signed [MEAN_W-1:0]  lmean;
    logic signed [COMO_W-1:0]  lcomo;
    logic signed [AC_W-1:0]    acorr;
  } stats_t;

  // one directed beat: optional lag write before, optional typed-in result
  typedef struct {
    int unsigned       lag_wr;
    logic signed [15:0] sample;
    bit                typed;
    stats_t            want;
  } vec_t;

  logic clk, rst_n;
  rmla_in_if  in_if ();
  rmla_cfg_if cfg_if ();
  rmla_out_if out_if ();

  running_mean_lag_autocovariance #(.MAX_LAG(LAGS)) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  // predictor state
  shortint     win_q [DEPTH];
  int unsigned fill_q;
  int unsigned seen_q;
  int          mean_q [DEPTH];
  longint      como_q [DEPTH];
  int unsigned lag_q;

  stats_t pending_stats [$];
  int unsigned mismatches;
  bit quiet;
  bit done;
  int unsigned stall_left;

  function automatic longint sat_sum(longint a, longint b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SAT_MIN : SAT_MAX;
    return longint'(s[63:0]);
  endfunction

  // q1.15 ratio, truncated toward zero
  function automatic logic signed [15:0] ratio_q15(longint num, longint den);
    longint unsigned a, d, r, q;
    bit neg;
    if (den == 0) return '0;
    neg = (num < 0) != (den < 0);
    a = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    if (a >= d) return neg ? AC_NEG_SAT : AC_POS_SAT;
    r = a;
    q = 0;
    for (int i = 0; i < 15; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    return neg ? -q[15:0] : q[15:0];
  endfunction

  // welford update of every filled lag, returns the beat the block should send
  function automatic stats_t acov_predict(logic signed [15:0] s);
    longint xq, m0, d1, d2, term, dv, m;
    longint unsigned a1, a2, xm, t, nn;
    int unsigned lag;
    stats_t r;
    if (seen_q != 32'hffffffff) seen_q++;
    nn = seen_q;
    for (int i = DEPTH - 1; i > 0; i--) win_q[i] = win_q[i-1];
    win_q[0] = s;
    if (fill_q < DEPTH) fill_q++;
    xq = longint'(s) * 65536;
    m0 = mean_q[0];
    for (int unsigned l = 0; l < fill_q; l++) begin
      d1 = xq - m0;
      d2 = longint'(win_q[l]) * 65536 - m0;
      a1 = d1 < 0 ? -d1 : d1;
      a2 = d2 < 0 ? -d2 : d2;
      xm = (a1 * a2) >> 16;
      t = xm - xm / nn;
      term = longint'(t);
      como_q[l] = sat_sum(como_q[l], ((d1 < 0) != (d2 < 0)) ? -term : term);
    end
    for (int unsigned l = 0; l < fill_q; l++) begin
      dv = longint'(nn) - longint'(l);
      if (dv < 1) dv = 1;
      m = mean_q[l];
      m = m + (xq - m) / dv;
      mean_q[l] = int'(m);
    end
    lag = lag_q > LAGS ? LAGS : lag_q;
    r.count    = seen_q;
    r.mean     = mean_q[0];
    r.variance = nn != 0 ? como_q[0] / longint'(nn) : 0;
    r.lmean    = mean_q[lag];
    r.lcomo    = como_q[lag];
    r.acorr    = ratio_q15(como_q[lag], como_q[0]);
    return r;
  endfunction

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // result side back-pressure in bursts
  initial begin
    out_if.ready = 1'b0;
    stall_left = 0;
  end
  always @(posedge clk) begin
    if (!quiet && stall_left == 0 && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 7);
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    stats_t got, exp;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.sample_count, out_if.running_mean, out_if.sample_variance,
              out_if.lag_mean, out_if.lag_comoment, out_if.autocorrelation};
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_N) $display("unexpected result beat %p", got);
      end else begin
        exp = pending_stats.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= REPORT_N)
            $display("mismatch: count %0d/%0d mean %0d/%0d var %0d/%0d",
                     exp.count, got.count, exp.mean, got.mean, exp.variance,
                     got.variance,
                     " lmean %0d/%0d lcomo %0d/%0d ac %0d/%0d",
                     exp.lmean, got.lmean, exp.lcomo, got.lcomo,
                     exp.acorr, got.acorr);
        end
      end
    end
  end

  task automatic write_lag(int unsigned v);
    while (pending_stats.size() != 0) @(posedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.query_lag <= v[3:0];
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    lag_q = v[3:0];
  endtask

  // one sample beat; valid is left high for the caller to drop
  task automatic send_sample(logic signed [15:0] s, bit typed, stats_t want);
    stats_t p;
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    p = acov_predict(s);
    pending_stats = {pending_stats, typed ? want : p};
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // stimulus
  initial begin
    vec_t vecs [$];
    vec_t v;
    stats_t none;
    logic signed [15:0] s;
    none = '0;
    in_if.valid = 1'b0;
    in_if.sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.query_lag = '0;
    quiet = 1'b0;
    mismatches = 0;
    done = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      win_q[i] = 0;
      mean_q[i] = 0;
      como_q[i] = 0;
    end
    fill_q = 0;
    seen_q = 0;
    lag_q = 0;

    // first beat after reset: mean is the sample, no spread yet
    vecs = {vecs, vec_t'{NO_CFG, 16'sh7fff, 1'b1,
                  '{32'd1, 32'sh7fff0000, 64'sd0, 32'sh7fff0000, 64'sd0, 16'sd0}}};
    vecs = {vecs, vec_t'{NO_CFG, -16'sd32768, 1'b0, none}};
    vecs = {vecs, vec_t'{NO_CFG, 16'sd0, 1'b0, none}};
    // lag not yet filled reads zero
    vecs = {vecs, vec_t'{5, -16'sd1, 1'b0, none}};
    vecs = {vecs, vec_t'{NO_CFG, 16'sd1, 1'b0, none}};
    vecs = {vecs, vec_t'{1, 16'sh7fff, 1'b0, none}};
    vecs = {vecs, vec_t'{NO_CFG, -16'sd32768, 1'b0, none}};
    vecs = {vecs, vec_t'{NO_CFG, 16'sh7fff, 1'b0, none}};
    vecs = {vecs, vec_t'{NO_CFG, -16'sd32768, 1'b0, none}};
    vecs = {vecs, vec_t'{8, 16'sh5555, 1'b0, none}};
    vecs = {vecs, vec_t'{NO_CFG, -16'sh5556, 1'b0, none}};
    vecs = {vecs, vec_t'{NO_CFG, 16'sd100, 1'b0, none}};
    // query past the deepest lag clamps
    vecs = {vecs, vec_t'{15, 16'sd200, 1'b0, none}};
    vecs = {vecs, vec_t'{NO_CFG, -16'sd300, 1'b0, none}};
    vecs = {vecs, vec_t'{2, 16'sd7, 1'b0, none}};
    vecs = {vecs, vec_t'{NO_CFG, 16'sd7, 1'b0, none}};
    vecs = {vecs, vec_t'{NO_CFG, -16'sd7, 1'b0, none}};
    vecs = {vecs, vec_t'{0, 16'sh0f0f, 1'b0, none}};
    vecs = {vecs, vec_t'{NO_CFG, -16'sh0f10, 1'b0, none}};
    vecs = {vecs, vec_t'{10, 16'sd1234, 1'b0, none}};

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    foreach (vecs[i]) begin
      v = vecs[i];
      if (v.lag_wr != NO_CFG) begin
        in_if.valid <= 1'b0;
        write_lag(v.lag_wr);
      end
      send_sample(v.sample, v.typed, v.want);
      maybe_gap();
    end

    // random samples, lag rewritten now and then once drained
    for (int unsigned k = 0; k < RAND_N; k++) begin
      if (k == RAND_N - QUIET_N) quiet = 1'b1;
      if (k % 150 == 75) begin
        in_if.valid <= 1'b0;
        case ((k / 150) % 4)
          0: write_lag(LAGS);
          1: write_lag(0);
          2: write_lag(15);
          default: write_lag($urandom_range(0, 15));
        endcase
      end
      case ($urandom_range(0, 3))
        0: s = 16'($urandom_range(0, 255) - 128);
        1: s = $urandom_range(0, 1) ? 16'sh7fff : -16'sd32768;
        default: s = 16'($urandom);
      endcase
      send_sample(s, 1'b0, none);
      maybe_gap();
    end
    in_if.valid <= 1'b0;

    while (pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    done = 1'b1;
    $finish;
  end

  // watchdog
  initial begin
    #60000000;
    if (!done) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

>>> running_mean_lag_autocovariance.f
hdl/rmla_pkg.sv
hdl/rmla_if.sv
hdl/rmla_cell.sv
hdl/rmla_div.sv
hdl/running_mean_lag_autocovariance.sv
hdl/rmla_checker.sv
sim/running_mean_lag_autocovariance_test.sv
